// File: rtl/arpc_pkg.sv
// Shared types, constants and codes for the ARP cache block.
package arpc_pkg;

  localparam int unsigned CACHE_DEPTH_DEF   = 32;
  localparam int unsigned PENDING_DEPTH_DEF = 16;

  localparam logic [7:0] TIMEOUT_RST = 8'd15;
  localparam logic [2:0] RETRIES_RST = 3'd5;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_APPEND = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_MISS    = 3'd0,
    K_HIT     = 3'd1,
    K_INSDONE = 3'd2,
    K_SEND    = 3'd3,
    K_RELEASE = 3'd4,
    K_UNREACH = 3'd5,
    K_QUEUED  = 3'd6,
    K_DONE    = 3'd7
  } kind_t;

  typedef enum logic {
    CFG_TIMEOUT = 1'b0,
    CFG_RETRIES = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
    logic [3:0]  iface_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] out_ip;
    logic [47:0] out_mac;
    logic [3:0]  out_iface;
    logic        last;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CSCAN,
    S_CWAIT,
    S_CHIT,
    S_CWRITE,
    S_PSCAN,
    S_PWAIT,
    S_PEMIT,
    S_AWRITE,
    S_FINAL,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input word
    logic cidx_clr;
    logic cidx_inc;
    logic cread;     // read cache at cidx
    logic cread_hit; // read cache at hit slot
    logic cwrite;    // insert write
    logic cage;      // tick aging write of cidx entry
    logic pidx_clr;
    logic pidx_inc;
    logic pread;
    logic pfree;     // clear pending valid at pidx
    logic pretry;    // retries++ at pidx
    logic pwrite;    // append at free slot
    logic emit;
    logic [2:0] kind;
    logic emit_pend; // use pending entry ip/iface
    logic emit_mac;  // use mac field
    logic emit_ifc;  // use input iface
    logic emit_last;
    logic out_take;
    logic out_rel;   // let held word go out, not last
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic cidx_end;
    logic pidx_end;
    logic cval;      // cache slot at cidx valid (from the valid register)
    logic cmatch;
    logic hit_found;
    logic pval;
    logic pmatch_ip;
    logic pmatch_full;
    logic pexhaust;
    logic pfree_found;
    logic found;
    logic out_busy;
    logic out_held;
  } sts_t;

endpackage

// File: rtl/arpc_ctrl.sv
// Sequencer that scans the cache and pending tables for one input word.
module arpc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  arpc_pkg::sts_t  sts,
  output arpc_pkg::cmd_t  cmd
);
  import arpc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = !sts.out_busy;
        if (in_valid && !sts.out_busy) begin
          cmd.load     = 1'b1;
          cmd.cidx_clr = 1'b1;
          cmd.pidx_clr = 1'b1;
          cmd.cread    = 1'b1;
          state_nxt    = S_CSCAN;
        end
      end
      S_CSCAN: begin
        if (sts.op == OP_APPEND) begin
          cmd.pread = 1'b1;
          state_nxt = S_PSCAN;
        end else begin
          state_nxt = S_CWAIT;
        end
      end
      S_CWAIT: begin
        // registered read of cidx is visible here
        if (sts.op == OP_TICK && sts.cval) begin
          cmd.cage = 1'b1;
        end
        if (sts.cidx_end) begin
          case (sts.op)
            OP_LOOKUP: begin
              if (sts.hit_found || (sts.cval && sts.cmatch)) begin
                cmd.cread_hit = 1'b1;
                state_nxt     = S_CHIT;
              end else begin
                cmd.emit      = 1'b1;
                cmd.kind      = K_MISS;
                cmd.emit_last = 1'b1;
                state_nxt     = S_OUT;
              end
            end
            OP_INSERT: state_nxt = S_CWRITE;
            default: begin
              cmd.pidx_clr = 1'b1;
              cmd.pread    = 1'b1;
              state_nxt    = S_PSCAN;
            end
          endcase
        end else begin
          cmd.cidx_inc = 1'b1;
          state_nxt    = S_CSCAN;
        end
      end
      S_CHIT: begin
        cmd.emit      = 1'b1;
        cmd.kind      = K_HIT;
        cmd.emit_mac  = 1'b1;
        cmd.emit_last = 1'b1;
        state_nxt     = S_OUT;
      end
      S_CWRITE: begin
        cmd.cwrite   = 1'b1;
        cmd.emit     = 1'b1;
        cmd.kind     = K_INSDONE;
        cmd.pidx_clr = 1'b1;
        state_nxt    = S_PSCAN;
      end
      S_PSCAN: begin
        if (!sts.out_busy) begin
          state_nxt = S_PWAIT;
        end
      end
      S_PWAIT: begin
        if (sts.pval && sts.op == OP_INSERT && sts.pmatch_ip) begin
          state_nxt = S_PEMIT;
        end else if (sts.pval && sts.op == OP_TICK) begin
          state_nxt = S_PEMIT;
        end else if (sts.pidx_end) begin
          state_nxt = (sts.op == OP_APPEND) ? S_AWRITE : S_FINAL;
        end else begin
          cmd.pidx_inc = 1'b1;
          state_nxt    = S_PSCAN;
        end
      end
      S_PEMIT: begin
        if (sts.out_held) begin
          cmd.out_rel = 1'b1;
        end else if (!sts.out_busy) begin
          cmd.emit      = 1'b1;
          cmd.emit_pend = 1'b1;
          if (sts.op == OP_INSERT) begin
            cmd.kind     = K_RELEASE;
            cmd.emit_mac = 1'b1;
            cmd.pfree    = 1'b1;
          end else if (sts.pexhaust) begin
            cmd.kind  = K_UNREACH;
            cmd.pfree = 1'b1;
          end else begin
            cmd.kind   = K_SEND;
            cmd.pretry = 1'b1;
          end
          if (sts.pidx_end) begin
            state_nxt = S_FINAL;
          end else begin
            cmd.pidx_inc = 1'b1;
            state_nxt    = S_PSCAN;
          end
        end
      end
      S_AWRITE: begin
        cmd.emit      = 1'b1;
        cmd.emit_last = 1'b1;
        if (sts.found) begin
          cmd.kind = K_QUEUED;
        end else if (!sts.pfree_found) begin
          cmd.kind = K_DONE;
        end else begin
          cmd.kind     = K_SEND;
          cmd.emit_ifc = 1'b1;
          cmd.pwrite   = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_FINAL: begin
        if (!sts.out_busy) begin
          if (sts.op == OP_TICK) begin
            cmd.emit      = 1'b1;
            cmd.kind      = K_DONE;
            cmd.emit_last = 1'b1;
          end else begin
            cmd.out_take = 1'b1; // mark held word as last
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: rtl/arpc_dp.sv
// Cache and pending tables, scan counters and the output register.
module arpc_dp #(
  parameter int unsigned CACHE_DEPTH   = arpc_pkg::CACHE_DEPTH_DEF,
  parameter int unsigned PENDING_DEPTH = arpc_pkg::PENDING_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  arpc_pkg::in_word_t  in_data,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  input  arpc_pkg::cmd_t      cmd,
  output arpc_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_ready,
  output arpc_pkg::out_word_t out_data
);
  import arpc_pkg::*;

  localparam int unsigned CW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int unsigned PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  logic [7:0] timeout_r;
  logic [2:0] retries_max_r;

  in_word_t   req_r;

  logic [CACHE_DEPTH-1:0]   cvalid_r;
  logic [31:0]              cip_mem   [CACHE_DEPTH];
  logic [47:0]              cmac_mem  [CACHE_DEPTH];
  logic [7:0]               cage_mem  [CACHE_DEPTH];
  logic [PENDING_DEPTH-1:0] pvalid_r;
  logic [31:0]              pip_mem   [PENDING_DEPTH];
  logic [3:0]               pifc_mem  [PENDING_DEPTH];
  logic [2:0]               pret_mem  [PENDING_DEPTH];

  logic [CW-1:0] cidx_r;
  logic [PW-1:0] pidx_r;
  logic [31:0]   cip_rd_r;
  logic [47:0]   cmac_rd_r;
  logic [7:0]    cage_rd_r;
  logic [31:0]   pip_rd_r;
  logic [3:0]    pifc_rd_r;
  logic [2:0]    pret_rd_r;

  logic [CW-1:0] hit_r;
  logic          hit_found_r;
  logic [CW-1:0] cfree_r;
  logic          cfree_found_r;
  logic [PW-1:0] pfree_r;
  logic          pfree_found_r;
  logic          found_r;

  out_word_t     out_r;
  logic          out_valid_r;
  logic          pend_tag_r;

  logic          cval;
  logic          cmatch;
  logic          pval;
  logic [CW-1:0] cread_addr;
  logic [CW-1:0] cw_addr;
  logic [PW-1:0] pread_addr;
  logic [7:0]    age_inc;

  assign cval   = cvalid_r[cidx_r];
  assign cmatch = (cip_rd_r == req_r.ip_addr);
  assign pval   = pvalid_r[pidx_r];
  assign cread_addr = cmd.cidx_clr ? '0 :
                      cmd.cread_hit ? (hit_found_r ? hit_r : cidx_r) :
                      (cmd.cidx_inc ? cidx_r + 1'b1 : cidx_r);
  assign cw_addr = hit_found_r ? hit_r : (cfree_found_r ? cfree_r : '0);
  assign pread_addr = cmd.pidx_clr ? '0 : (cmd.pidx_inc ? pidx_r + 1'b1 : pidx_r);
  assign age_inc = (cage_rd_r == 8'hFF) ? cage_rd_r : cage_rd_r + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= TIMEOUT_RST;
      retries_max_r <= RETRIES_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TIMEOUT: timeout_r     <= cfg_data;
        CFG_RETRIES: retries_max_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // cache memory
  always_ff @(posedge clk) begin
    if (cmd.cread || cmd.cidx_inc || cmd.cread_hit) begin
      cip_rd_r  <= cip_mem[cread_addr];
      cmac_rd_r <= cmac_mem[cread_addr];
      cage_rd_r <= cage_mem[cread_addr];
    end
    if (cmd.cwrite) begin
      cip_mem[cw_addr]  <= req_r.ip_addr;
      cmac_mem[cw_addr] <= req_r.mac_addr;
      cage_mem[cw_addr] <= 8'd0;
    end else if (cmd.cage) begin
      cage_mem[cidx_r] <= age_inc;
    end
  end

  // pending memory
  always_ff @(posedge clk) begin
    if (cmd.pread || cmd.pidx_inc || cmd.pidx_clr) begin
      pip_rd_r  <= pip_mem[pread_addr];
      pifc_rd_r <= pifc_mem[pread_addr];
      pret_rd_r <= pret_mem[pread_addr];
    end
    if (cmd.pwrite) begin
      pip_mem[pfree_r]  <= req_r.ip_addr;
      pifc_mem[pfree_r] <= req_r.iface_id;
      pret_mem[pfree_r] <= 3'd0;
    end else if (cmd.pretry) begin
      pret_mem[pidx_r] <= pret_rd_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvalid_r      <= '0;
      pvalid_r      <= '0;
      cidx_r        <= '0;
      pidx_r        <= '0;
      hit_found_r   <= 1'b0;
      cfree_found_r <= 1'b0;
      pfree_found_r <= 1'b0;
      found_r       <= 1'b0;
      hit_r         <= '0;
      cfree_r       <= '0;
      pfree_r       <= '0;
    end else begin
      if (cmd.cidx_clr) begin
        cidx_r        <= '0;
        hit_found_r   <= 1'b0;
        cfree_found_r <= 1'b0;
      end else if (cmd.cidx_inc) begin
        cidx_r <= cidx_r + 1'b1;
      end
      if (cmd.load) begin
        pfree_found_r <= 1'b0;
        found_r       <= 1'b0;
      end
      if (cmd.pidx_clr) begin
        pidx_r <= '0;
      end else if (cmd.pidx_inc) begin
        pidx_r <= pidx_r + 1'b1;
      end
      // cache scan bookkeeping, one slot per visit of the compare state
      if (!cmd.cidx_clr && (cmd.cidx_inc || cmd.cage || cmd.cread_hit ||
                            (sts.cidx_end && !cmd.cwrite))) begin
        if (cval && cmatch && !hit_found_r) begin
          hit_found_r <= 1'b1;
          hit_r       <= cidx_r;
        end
        if (!cval && !cfree_found_r) begin
          cfree_found_r <= 1'b1;
          cfree_r       <= cidx_r;
        end
      end
      if (cmd.cage && ((age_inc > timeout_r))) begin
        cvalid_r[cidx_r] <= 1'b0;
      end
      if (cmd.cwrite) begin
        cvalid_r[cw_addr] <= 1'b1;
      end
      // append scan bookkeeping
      if (req_r.op == OP_APPEND && !cmd.load && !cmd.pwrite &&
          (cmd.pidx_inc || (sts.pidx_end && !cmd.emit))) begin
        if (pval && pip_rd_r == req_r.ip_addr && pifc_rd_r == req_r.iface_id) begin
          found_r <= 1'b1;
        end
        if (!pval && !pfree_found_r) begin
          pfree_found_r <= 1'b1;
          pfree_r       <= pidx_r;
        end
      end
      if (cmd.pfree) begin
        pvalid_r[pidx_r] <= 1'b0;
      end
      if (cmd.pwrite) begin
        pvalid_r[pfree_r] <= 1'b1;
      end
    end
  end

  // output register; insert words may later be tagged last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.out_take) begin
        out_r.last <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r     <= 1'b1;
        out_r.kind      <= cmd.kind;
        out_r.out_ip    <= (cmd.emit_pend && req_r.op == OP_TICK) ? pip_rd_r :
                           ((cmd.kind == K_DONE && req_r.op == OP_TICK) ?
                            32'd0 : req_r.ip_addr);
        out_r.out_mac   <= !cmd.emit_mac ? 48'd0 :
                           (cmd.emit_pend ? req_r.mac_addr : cmac_rd_r);
        out_r.out_iface <= cmd.emit_pend ? pifc_rd_r :
                           (cmd.emit_ifc ? req_r.iface_id : 4'd0);
        out_r.last      <= cmd.emit_last;
      end
    end
  end

  // insert holds each word it emits until released or tagged last
  assign out_valid = out_valid_r && !(pend_tag_r);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_tag_r <= 1'b0;
    end else if (cmd.emit && req_r.op == OP_INSERT) begin
      pend_tag_r <= 1'b1;
    end else if (cmd.out_take || cmd.out_rel) begin
      pend_tag_r <= 1'b0;
    end
  end

  assign out_data = out_r;

  always_comb begin
    sts             = '0;
    sts.op          = op_t'(req_r.op);
    sts.cidx_end    = (cidx_r == CW'(CACHE_DEPTH - 1));
    sts.pidx_end    = (pidx_r == PW'(PENDING_DEPTH - 1));
    sts.cval        = cval;
    sts.cmatch      = cmatch;
    sts.hit_found   = hit_found_r;
    sts.pval        = pval;
    sts.pmatch_ip   = (pip_rd_r == req_r.ip_addr);
    sts.pmatch_full = sts.pmatch_ip && (pifc_rd_r == req_r.iface_id);
    sts.pexhaust    = (pret_rd_r >= retries_max_r);
    sts.pfree_found = pfree_found_r;
    sts.found       = found_r;
    sts.out_busy    = out_valid_r && !pend_tag_r;
    sts.out_held    = pend_tag_r;
  end

endmodule

// File: rtl/arp_cache_with_pending_retries.sv
// Top level of the ARP cache with aging and pending request retries.
// A lookup scans the cache, an append the pending table, and an insert or a tick both;
// the scans visit one slot at a time and wait for each result word to leave, so output
// stalls lengthen them.
// Throughput: one input word at a time; results leave through one output register.
// Reset: synchronous active-low rst_n clears all valid bits, registers to defaults.
module arp_cache_with_pending_retries #(
  parameter int unsigned CACHE_DEPTH   = arpc_pkg::CACHE_DEPTH_DEF,
  parameter int unsigned PENDING_DEPTH = arpc_pkg::PENDING_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  arpc_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output arpc_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import arpc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  arpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  arpc_dp #(
    .CACHE_DEPTH   (CACHE_DEPTH),
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index[0]),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the ARP cache with pending request retries.
`timescale 1ns / 1ps

module tb_top;
  import arpc_pkg::*;

  localparam int CD = CACHE_DEPTH_DEF;
  localparam int PD = PENDING_DEPTH_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  arp_cache_with_pending_retries i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow state of the cache and pending tables
  logic        c_val [CD];
  logic [31:0] c_ip  [CD];
  logic [47:0] c_mac [CD];
  logic [7:0]  c_age [CD];
  logic        p_val [PD];
  logic [31:0] p_ip  [PD];
  logic [3:0]  p_ifc [PD];
  logic [2:0]  p_try [PD];
  logic [7:0]  timeout_sh = TIMEOUT_RST;
  logic [2:0]  retries_sh = RETRIES_RST;

  in_word_t  req_q[$];
  out_word_t arp_events_q[$];
  int errors = 0;
  int gap = 0;
  int hold = 0;
  int hold_req = 0;
  bit quiet = 1'b0;
  logic [31:0] pool [8];

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void push_event(kind_t k, logic [31:0] ip, logic [47:0] mac,
                                     logic [3:0] ifc);
    out_word_t r;
    r.kind = k;
    r.out_ip = ip;
    r.out_mac = mac;
    r.out_iface = ifc;
    r.last = 1'b0;
    arp_events_q.push_back(r);
  endfunction

  function automatic void predict_arp(in_word_t w);
    int pos;
    int fs;
    bit found;
    pos = -1;
    fs = -1;
    found = 1'b0;
    case (op_t'(w.op))
      OP_LOOKUP: begin
        for (int i = 0; i < CD; i++)
          if (pos < 0 && c_val[i] && c_ip[i] == w.ip_addr) pos = i;
        if (pos >= 0) push_event(K_HIT, w.ip_addr, c_mac[pos], '0);
        else push_event(K_MISS, w.ip_addr, '0, '0);
      end
      OP_INSERT: begin
        for (int i = 0; i < CD; i++)
          if (pos < 0 && c_val[i] && c_ip[i] == w.ip_addr) pos = i;
        for (int i = 0; i < CD; i++)
          if (pos < 0 && !c_val[i]) pos = i;
        if (pos < 0) pos = 0;
        c_val[pos] = 1'b1;
        c_ip[pos] = w.ip_addr;
        c_mac[pos] = w.mac_addr;
        c_age[pos] = '0;
        push_event(K_INSDONE, w.ip_addr, '0, '0);
        for (int i = 0; i < PD; i++)
          if (p_val[i] && p_ip[i] == w.ip_addr) begin
            push_event(K_RELEASE, w.ip_addr, w.mac_addr, p_ifc[i]);
            p_val[i] = 1'b0;
          end
      end
      OP_APPEND: begin
        for (int i = 0; i < PD; i++)
          if (p_val[i]) begin
            if (p_ip[i] == w.ip_addr && p_ifc[i] == w.iface_id) found = 1'b1;
          end else if (fs < 0) begin
            fs = i;
          end
        if (found) push_event(K_QUEUED, w.ip_addr, '0, '0);
        else if (fs < 0) push_event(K_DONE, w.ip_addr, '0, '0);
        else begin
          p_val[fs] = 1'b1;
          p_ip[fs] = w.ip_addr;
          p_ifc[fs] = w.iface_id;
          p_try[fs] = '0;
          push_event(K_SEND, w.ip_addr, '0, w.iface_id);
        end
      end
      default: begin
        for (int i = 0; i < CD; i++)
          if (c_val[i]) begin
            if (c_age[i] != 8'hff) c_age[i]++;
            if (c_age[i] > timeout_sh) c_val[i] = 1'b0;
          end
        for (int i = 0; i < PD; i++)
          if (p_val[i]) begin
            if (p_try[i] >= retries_sh) begin
              push_event(K_UNREACH, p_ip[i], '0, p_ifc[i]);
              p_val[i] = 1'b0;
            end else begin
              push_event(K_SEND, p_ip[i], '0, p_ifc[i]);
              p_try[i]++;
            end
          end
        push_event(K_DONE, '0, '0, '0);
      end
    endcase
    arp_events_q[arp_events_q.size() - 1].last = 1'b1;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_arp(in_data);
      if (!in_valid || in_ready) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          in_data <= req_q.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (arp_events_q.size() == 0) begin
          $error("unexpected word kind=%0d ip=%h", out_data.kind, out_data.out_ip);
          errors++;
        end else begin
          e = arp_events_q.pop_front();
          if (out_data.kind !== e.kind) begin
            $error("kind exp %0d got %0d", e.kind, out_data.kind);
            errors++;
          end
          if (out_data.out_ip !== e.out_ip) begin
            $error("out_ip exp %h got %h", e.out_ip, out_data.out_ip);
            errors++;
          end
          if (out_data.out_mac !== e.out_mac) begin
            $error("out_mac exp %h got %h", e.out_mac, out_data.out_mac);
            errors++;
          end
          if (out_data.out_iface !== e.out_iface) begin
            $error("out_iface exp %0d got %0d", e.out_iface, out_data.out_iface);
            errors++;
          end
          if (out_data.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_data.last);
            errors++;
          end
        end
      end
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_word_t mk(op_t o, logic [31:0] ip, logic [47:0] mac,
                                  logic [3:0] ifc);
    in_word_t w;
    w.op = o;
    w.ip_addr = ip;
    w.mac_addr = mac;
    w.iface_id = ifc;
    return w;
  endfunction

  function automatic in_word_t rnd_word();
    logic [31:0] ip;
    logic [47:0] mac;
    int r;
    ip = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 7)] : $urandom;
    mac = {$urandom, $urandom};
    r = $urandom_range(0, 9);
    if (r < 3) return mk(OP_LOOKUP, ip, mac, 4'($urandom));
    if (r < 5) return mk(OP_INSERT, ip, mac, 4'($urandom));
    if (r < 8) return mk(OP_APPEND, ip, mac, 4'($urandom_range(0, 3) * 5));
    return mk(OP_TICK, ip, mac, 4'($urandom));
  endfunction

  task automatic drain();
    do @(posedge clk);
    while (req_q.size() > 0 || in_valid || arp_events_q.size() > 0);
    repeat (150) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == CFG_TIMEOUT) timeout_sh = v;
    else retries_sh = v[2:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic set_cfg(logic [7:0] tmo, logic [7:0] rtr);
    drain();
    cfg_write(CFG_TIMEOUT, tmo);
    cfg_write(CFG_RETRIES, rtr);
  endtask

  initial begin
    for (int i = 0; i < CD; i++) c_val[i] = 1'b0;
    for (int i = 0; i < PD; i++) p_val[i] = 1'b0;
    pool[0] = 32'h0;
    pool[1] = 32'hffff_ffff;
    for (int i = 2; i < 8; i++) pool[i] = $urandom;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    req_q.push_back(mk(OP_LOOKUP, 32'h0, 48'h0, 4'h0));
    req_q.push_back(mk(OP_INSERT, 32'h0, 48'h0, 4'h0));
    req_q.push_back(mk(OP_INSERT, 32'hffff_ffff, 48'hffff_ffff_ffff, 4'hf));
    req_q.push_back(mk(OP_LOOKUP, 32'h0, 48'hffff_ffff_ffff, 4'hf));
    req_q.push_back(mk(OP_LOOKUP, 32'hffff_ffff, 48'h0, 4'h0));
    req_q.push_back(mk(OP_APPEND, pool[2], 48'h0, 4'hf));
    req_q.push_back(mk(OP_APPEND, pool[2], 48'h0, 4'hf));
    req_q.push_back(mk(OP_APPEND, pool[2], 48'hffff_ffff_ffff, 4'h0));
    req_q.push_back(mk(OP_TICK, 32'hffff_ffff, 48'hffff_ffff_ffff, 4'hf));
    req_q.push_back(mk(OP_INSERT, pool[2], 48'h1234_5678_9abc, 4'h0));
    req_q.push_back(mk(OP_APPEND, pool[3], 48'h0, 4'h3));
    repeat (7) req_q.push_back(mk(OP_TICK, 32'h0, 48'h0, 4'h0));
    req_q.push_back(mk(OP_LOOKUP, pool[2], 48'h0, 4'h0));

    set_cfg(8'd0, 8'd0);
    req_q.push_back(mk(OP_INSERT, pool[4], {$urandom, $urandom}, 4'h0));
    req_q.push_back(mk(OP_APPEND, pool[5], 48'h0, 4'h9));
    req_q.push_back(mk(OP_TICK, 32'h0, 48'h0, 4'h0));
    req_q.push_back(mk(OP_LOOKUP, pool[4], 48'h0, 4'h0));

    set_cfg(8'd255, 8'd7);
    for (int i = 0; i < PD + 2; i++)
      req_q.push_back(mk(OP_APPEND, $urandom, 48'h0, 4'($urandom)));
    for (int i = 0; i < CD + 4; i++)
      req_q.push_back(mk(OP_INSERT, $urandom, {$urandom, $urandom}, 4'h0));
    repeat (9) req_q.push_back(mk(OP_TICK, 32'h0, 48'h0, 4'h0));
    req_q.push_back(mk(OP_LOOKUP, 32'h0, 48'h0, 4'h0));

    set_cfg(8'd1, 8'd2);
    for (int i = 0; i < 50; i++) req_q.push_back(rnd_word());
    repeat (40) @(posedge clk);
    hold_req = 400;

    set_cfg(8'd254, 8'd3);
    for (int i = 0; i < 40; i++) req_q.push_back(rnd_word());
    set_cfg(8'd4, 8'd1);
    quiet = 1'b1;
    for (int i = 0; i < 30; i++) req_q.push_back(rnd_word());
    drain();

    if (errors == 0 && arp_events_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
rtl/arpc_pkg.sv
rtl/arpc_ctrl.sv
rtl/arpc_dp.sv
rtl/arp_cache_with_pending_retries.sv
bench/tb_top.sv
